FILE: design/tcme_pkg.sv
// Shared types and constants for the chained TEA message encipherer.
`timescale 1ns / 1ps
package tcme_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int ROUNDS_DEF      = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// one plaintext block waiting to be enciphered
	typedef struct packed {
		logic [63:0] block;
		logic        last;
		logic        restart;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

endpackage

FILE: design/tcme_if.sv
// Stream channels: plaintext byte words in, ciphertext block words out.
`timescale 1ns / 1ps
interface tcme_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        start_req;
	logic [15:0] message_length;
	logic [4:0]  rand_head;
	logic [7:0]  rand_fill;
	logic [15:0] rand_salt;

	modport source (output valid, data_byte, start_req, message_length, rand_head,
		rand_fill, rand_salt, input ready);
	modport sink (input valid, data_byte, start_req, message_length, rand_head,
		rand_fill, rand_salt, output ready);
endinterface

interface tcme_block_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_block;
	logic        final_block;

	modport source (output valid, cipher_block, final_block, input ready);
	modport sink (input valid, cipher_block, final_block, output ready);
endinterface

FILE: design/tcme_front.sv
// Front end: frames the byte stream into 8-byte plaintext blocks.
`timescale 1ns / 1ps
module tcme_front #(
	parameter int LENGTH_BITS = tcme_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	tcme_byte_if.sink       plain,
	input  logic            q_full,
	output tcme_pkg::push_t push
);

	logic [63:0]            buf_q;
	logic [2:0]             pos_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic                   active_q;
	logic                   pend_q;
	tcme_pkg::job_t         hold_q;
	logic                   hold_valid_q;

	logic                   fire;
	logic [LENGTH_BITS-1:0] len_ext;
	logic [2:0]             pad;
	logic [3:0]             pad4;
	logic [3:0]             n_bytes;
	logic [7:0]             hdr;
	logic [7:0]             sb [0:10];
	logic [63:0]            head_blk;
	logic [63:0]            tail_blk;
	logic [63:0]            merged;
	logic [63:0]            closing;

	logic [63:0]            buf_d;
	logic [2:0]             pos_d;
	logic [LENGTH_BITS-1:0] rem_d;
	logic                   active_d;
	logic                   pend_d;
	tcme_pkg::job_t         job0, job1;
	logic                   job0_v, job1_v;

	assign fire        = plain.valid && plain.ready;
	assign plain.ready = !hold_valid_q && !q_full;

	assign len_ext = LENGTH_BITS'(plain.message_length);
	// pad makes header+pad+salt+plaintext less its last byte whole blocks
	assign pad     = 3'd6 - len_ext[2:0];
	assign pad4    = {1'b0, pad};
	assign n_bytes = pad4 + 4'd4;
	assign hdr     = {plain.rand_head, pad};
	assign closing = {plain.data_byte, 56'd0};
	assign merged  = buf_q | ({56'd0, plain.data_byte} << (6'd56 - {pos_q, 3'b000}));

	// framing stream on start: header, fill bytes, salt, first data byte
	always_comb begin
		for (int i = 0; i < 11; i++) begin
			if (4'(i) == 4'd0)
				sb[i] = hdr;
			else if (4'(i) <= pad4)
				sb[i] = plain.rand_fill;
			else if (4'(i) == pad4 + 4'd1)
				sb[i] = plain.rand_salt[15:8];
			else if (4'(i) == pad4 + 4'd2)
				sb[i] = plain.rand_salt[7:0];
			else if (4'(i) == pad4 + 4'd3)
				sb[i] = plain.data_byte;
			else
				sb[i] = 8'd0;
		end
		head_blk = '0;
		tail_blk = '0;
		for (int i = 0; i < 8; i++)
			head_blk[63-8*i -: 8] = sb[i];
		for (int i = 0; i < 3; i++)
			tail_blk[63-8*i -: 8] = sb[8+i];
	end

	always_comb begin
		buf_d    = buf_q;
		pos_d    = pos_q;
		rem_d    = rem_q;
		active_d = active_q;
		pend_d   = pend_q;
		job0     = '0;
		job1     = '0;
		job0_v   = 1'b0;
		job1_v   = 1'b0;
		if (plain.start_req) begin
			active_d = 1'b0;
			if (len_ext != '0) begin
				if (len_ext == LENGTH_BITS'(1)) begin
					// framing fills exactly one block, then the closing block
					job0   = '{block: head_blk, last: 1'b0, restart: 1'b1};
					job1   = '{block: closing, last: 1'b1, restart: 1'b0};
					job0_v = 1'b1;
					job1_v = 1'b1;
					buf_d  = '0;
					pos_d  = '0;
					rem_d  = '0;
					pend_d = 1'b0;
				end else begin
					active_d = 1'b1;
					rem_d    = len_ext - LENGTH_BITS'(1);
					if (n_bytes >= 4'd8) begin
						job0   = '{block: head_blk, last: 1'b0, restart: 1'b1};
						job0_v = 1'b1;
						buf_d  = tail_blk;
						pos_d  = 3'(n_bytes - 4'd8);
						pend_d = 1'b0;
					end else begin
						buf_d  = head_blk;
						pos_d  = n_bytes[2:0];
						pend_d = 1'b1;
					end
				end
			end
		end else if (active_q) begin
			if (rem_q <= LENGTH_BITS'(1)) begin
				job0     = '{block: closing, last: 1'b1, restart: pend_q};
				job0_v   = 1'b1;
				pend_d   = 1'b0;
				buf_d    = '0;
				pos_d    = '0;
				rem_d    = '0;
				active_d = 1'b0;
			end else begin
				rem_d = rem_q - LENGTH_BITS'(1);
				if (pos_q == 3'd7) begin
					job0   = '{block: merged, last: 1'b0, restart: pend_q};
					job0_v = 1'b1;
					pend_d = 1'b0;
					buf_d  = '0;
					pos_d  = '0;
				end else begin
					buf_d = merged;
					pos_d = pos_q + 3'd1;
				end
			end
		end
	end

	// a held second block goes first; no word is taken while one is held
	always_comb begin
		if (hold_valid_q) begin
			push.valid = !q_full;
			push.job   = hold_q;
		end else begin
			push.valid = fire && job0_v;
			push.job   = job0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q        <= '0;
			pos_q        <= '0;
			rem_q        <= '0;
			active_q     <= 1'b0;
			pend_q       <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				buf_q    <= buf_d;
				pos_q    <= pos_d;
				rem_q    <= rem_d;
				active_q <= active_d;
				pend_q   <= pend_d;
			end
			if (fire && job1_v)
				hold_valid_q <= 1'b1;
			else if (hold_valid_q && !q_full)
				hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && job1_v)
			hold_q <= job1;
	end

`ifndef ASSERT_OFF
	a_active_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> rem_q != '0)
		else $error("active message with no bytes remaining");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_full)
		else $error("block pushed into a full queue");
`endif

endmodule

FILE: design/tcme_job_fifo.sv
// Short queue of plaintext blocks between framing front end and cipher engine.
`timescale 1ns / 1ps
module tcme_job_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  tcme_pkg::push_t push,
	input  logic            pop,
	output tcme_pkg::job_t  head,
	output logic            empty,
	output logic            full
);

	localparam int DEPTH = tcme_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcme_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr, rd;

	assign empty = count_q == '0;
	assign full  = count_q == CNT_W'(DEPTH);
	assign head  = mem_q[rd_ptr_q];
	assign wr    = push.valid && !full;
	assign rd    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (wr && !rd)
				count_q <= count_q + CNT_W'(1);
			else if (rd && !wr)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= push.job;
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

FILE: design/tcme_tea_engine.sv
// Back end: chained TEA encipher, one round per cycle, last round held while the output register is full.
`timescale 1ns / 1ps
module tcme_tea_engine #(
	parameter int ROUNDS = tcme_pkg::ROUNDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcme_pkg::cfg_wr_t cfg,
	input  tcme_pkg::job_t    job,
	input  logic              job_avail,
	output logic              job_take,
	tcme_block_if.source      cipher
);

	localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS - 1);

	logic [31:0]   key_q [4];
	logic          busy_q;
	logic [RW-1:0] rnd_q;
	logic [31:0]   sum_q;
	logic [31:0]   y_q, z_q;
	logic [63:0]   mix_q;
	logic [63:0]   pm_q;
	logic [63:0]   prev_c_q;
	logic          last_q;
	logic          out_valid_q;
	logic [63:0]   out_block_q;
	logic          out_final_q;

	logic [31:0]   f_y, f_z, y_n, z_n;
	logic [63:0]   c_new, chain_c, load_mix, load_pm;
	logic          out_free, last_rnd, finishing, advance;

	// one full TEA round
	assign f_y   = ((z_q << 4) + key_q[0]) ^ (z_q + sum_q) ^ ((z_q >> 5) + key_q[1]);
	assign y_n   = y_q + f_y;
	assign f_z   = ((y_n << 4) + key_q[2]) ^ (y_n + sum_q) ^ ((y_n >> 5) + key_q[3]);
	assign z_n   = z_q + f_z;
	assign c_new = {y_n, z_n} ^ pm_q;

	assign out_free  = !out_valid_q || cipher.ready;
	assign last_rnd  = rnd_q == LAST_RND;
	assign finishing = busy_q && last_rnd && out_free;
	assign advance   = busy_q && (!last_rnd || out_free);
	assign job_take  = job_avail && (!busy_q || finishing);

	// chaining values forwarded from a block finishing in this cycle;
	// mix_q already holds the previous mixed input in either case
	assign chain_c  = finishing ? c_new : prev_c_q;
	assign load_mix = job.block ^ (job.restart ? 64'd0 : chain_c);
	assign load_pm  = job.restart ? 64'd0 : mix_q;

	assign cipher.valid        = out_valid_q;
	assign cipher.cipher_block = out_block_q;
	assign cipher.final_block  = out_final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				key_q[i] <= '0;
			busy_q      <= 1'b0;
			rnd_q       <= '0;
			sum_q       <= '0;
			mix_q       <= '0;
			prev_c_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					tcme_pkg::CFG_KEY0: key_q[0] <= cfg.data;
					tcme_pkg::CFG_KEY1: key_q[1] <= cfg.data;
					tcme_pkg::CFG_KEY2: key_q[2] <= cfg.data;
					tcme_pkg::CFG_KEY3: key_q[3] <= cfg.data;
					default: ;
				endcase
			end
			if (job_take) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				sum_q  <= tcme_pkg::TEA_DELTA;
				mix_q  <= load_mix;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				rnd_q <= rnd_q + RW'(1);
				sum_q <= sum_q + tcme_pkg::TEA_DELTA;
			end
			if (finishing) begin
				prev_c_q    <= c_new;
				out_valid_q <= 1'b1;
			end else if (cipher.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			y_q    <= load_mix[63:32];
			z_q    <= load_mix[31:0];
			pm_q   <= load_pm;
			last_q <= job.last;
		end else if (advance && !finishing) begin
			y_q <= y_n;
			z_q <= z_n;
		end
		if (finishing) begin
			out_block_q <= c_new;
			out_final_q <= last_q;
		end
	end

`ifndef ASSERT_OFF
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rnd_q <= LAST_RND)
		else $error("round counter beyond last round");
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		finishing |=> out_valid_q)
		else $error("finished block not presented");
`endif

endmodule

FILE: design/tea_chained_message_encrypt.sv
// Top level of the chained TEA message encipherer.
`timescale 1ns / 1ps
// Usage:
//  plain  : one plaintext byte per word. A word with start_req set opens a
//           message and also brings message_length, rand_head, rand_fill and
//           rand_salt; a zero length is dropped. Bytes outside a message are
//           dropped. A new start abandons any message in progress.
//  cipher : one 8-byte ciphertext block per word, first byte in bits 63:56;
//           final_block marks the closing block of a message.
//  cfg_*  : key words 0..3, to be written only while the block is idle;
//           a rule for the user that the block itself does not enforce.
// A completed block passes through the queue and the engine's rounds to the output register.
// Bytes are taken one per cycle while the block queue has room and no second
// block is held; the TEA engine runs one round per cycle and takes the next
// block as the previous one finishes its last round. A start that yields two
// blocks holds plain.ready low until the second block enters the queue.
// Reset clears keys, framing state, chaining values and the queue; no
// clearing pass. If cipher.ready stays low, the output register holds, the
// engine parks on its last round, then the queue fills and plain.ready drops.
module tea_chained_message_encrypt #(
	parameter int LENGTH_BITS = tcme_pkg::LENGTH_BITS_DEF,
	parameter int ROUNDS      = tcme_pkg::ROUNDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tcme_byte_if.sink                       plain,
	tcme_block_if.source                    cipher,
	input  logic                            cfg_we,
	input  logic [tcme_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcme_pkg::CFG_DATA_W-1:0] cfg_data
);

	tcme_pkg::cfg_wr_t cfg;
	tcme_pkg::push_t   push;
	tcme_pkg::job_t    head;
	logic              q_empty, q_full, job_take;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	// framing: header, fill, salt and plaintext into 8-byte blocks
	tcme_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.plain  (plain),
		.q_full (q_full),
		.push   (push)
	);

	// decouples byte intake from the multi-cycle cipher
	tcme_job_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (job_take),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// chaining and TEA rounds, output register toward cipher
	tcme_tea_engine #(.ROUNDS(ROUNDS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (head),
		.job_avail (!q_empty),
		.job_take  (job_take),
		.cipher    (cipher)
	);

endmodule

FILE: dv/tb_tea_chained_message_encrypt.sv
// Testbench for the chained TEA message encipherer: random framed messages against a predictor.
`timescale 1ns / 1ps
module tb_tea_chained_message_encrypt;

	// quiet cycles after the last expected block, to let the engine settle
	localparam int DRAIN_CYCLES = tcme_pkg::ROUNDS_DEF + 8;
	// counted plaintext words per random phase (four phases)
	localparam int PHASE_WORDS  = 410;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start_req;
		logic [15:0] message_length;
		logic [4:0]  rand_head;
		logic [7:0]  rand_fill;
		logic [15:0] rand_salt;
	} plain_word_t;

	typedef struct packed {
		logic [63:0] cipher_block;
		logic        final_block;
	} cipher_word_t;

	// Predicts the ciphertext stream and checks what the block emits.
	// Framing, chaining and key state are kept here and advanced on every
	// accepted plaintext word; finished blocks queue up as expected words.
	class cipher_scoreboard;
		logic [31:0]  key [4];
		logic [63:0]  frame_buf;
		int unsigned  frame_pos;
		logic [63:0]  prev_cipher;
		logic [63:0]  prev_mixed;
		logic [15:0]  bytes_left;
		bit           in_message;
		cipher_word_t expected_q [$];
		int unsigned  errors;

		function new();
			for (int i = 0; i < 4; i++) key[i] = '0;
			frame_buf   = '0;
			frame_pos   = 0;
			prev_cipher = '0;
			prev_mixed  = '0;
			bytes_left  = '0;
			in_message  = 0;
			errors      = 0;
		endfunction

		function void set_key(logic [tcme_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
			key[idx] = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// big-endian TEA, upper word first
		function logic [63:0] tea_encipher(logic [63:0] blk);
			logic [31:0] y;
			logic [31:0] z;
			logic [31:0] sum;
			y   = blk[63:32];
			z   = blk[31:0];
			sum = '0;
			for (int r = 0; r < tcme_pkg::ROUNDS_DEF; r++) begin
				sum = sum + tcme_pkg::TEA_DELTA;
				y = y + (((z << 4) + key[0]) ^ (z + sum) ^ ((z >> 5) + key[1]));
				z = z + (((y << 4) + key[2]) ^ (y + sum) ^ ((y >> 5) + key[3]));
			end
			return {y, z};
		endfunction

		// mix with the previous ciphertext, encipher, mix with the previous input
		function void chain_out(logic [63:0] blk, logic last);
			cipher_word_t w;
			logic [63:0] mixed;
			mixed          = blk ^ prev_cipher;
			w.cipher_block = tea_encipher(mixed) ^ prev_mixed;
			w.final_block  = last;
			prev_cipher    = w.cipher_block;
			prev_mixed     = mixed;
			expected_q.push_back(w);
		endfunction

		// first byte of a block lands in bits 63:56
		function void shift_in(logic [7:0] b);
			frame_buf[63 - 8 * frame_pos -: 8] = b;
			frame_pos++;
			if (frame_pos == 8) begin
				chain_out(frame_buf, 1'b0);
				frame_buf = '0;
				frame_pos = 0;
			end
		endfunction

		// returns 0 when the block simply drops the word (no message open)
		function bit note_input(plain_word_t w);
			logic [2:0] pad;
			if (w.start_req) begin
				in_message = 0;
				// zero length: rejected, chaining values kept
				if (w.message_length == '0) return 1;
				// pad so that header + pad + salt + plaintext, less its last byte, fills whole blocks:
				// (len + 10 + pad) mod 8 == 0
				pad         = 3'd0 - (w.message_length[2:0] + 3'd2);
				prev_cipher = '0;
				prev_mixed  = '0;
				frame_buf   = '0;
				frame_pos   = 0;
				bytes_left  = w.message_length;
				in_message  = 1;
				shift_in({w.rand_head, pad});
				for (int i = 0; i < pad; i++) shift_in(w.rand_fill);
				shift_in(w.rand_salt[15:8]);
				shift_in(w.rand_salt[7:0]);
			end else if (!in_message) begin
				return 0;
			end
			if (bytes_left <= 16'd1) begin
				// last plaintext byte opens the closing block, rest zero
				chain_out({w.data_byte, 56'b0}, 1'b1);
				frame_buf  = '0;
				frame_pos  = 0;
				bytes_left = '0;
				in_message = 0;
			end else begin
				shift_in(w.data_byte);
				bytes_left = bytes_left - 16'd1;
			end
			return 1;
		endfunction

		function void check_result(cipher_word_t got);
			cipher_word_t want;
			if (expected_q.size() == 0) begin
				$error("cipher word with none expected: cipher_block %h final_block %b",
					got.cipher_block, got.final_block);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.cipher_block !== want.cipher_block) begin
				$error("cipher_block: expected %h, actual %h",
					want.cipher_block, got.cipher_block);
				errors++;
			end
			if (got.final_block !== want.final_block) begin
				$error("final_block: expected %b, actual %b",
					want.final_block, got.final_block);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [tcme_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tcme_pkg::CFG_DATA_W-1:0] cfg_data;
	bit                              no_idle;     // both sides run flat out while set
	int unsigned                     words_sent;  // accepted words the block acted on

	tcme_byte_if  plain ();
	tcme_block_if cipher ();

	cipher_scoreboard sb = new();

	tea_chained_message_encrypt i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.plain     (plain),
		.cipher    (cipher),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("tea_chained_message_encrypt test failed");
		$finish;
	end

	// Receiver: drops ready about a quarter of the time unless no_idle is set.
	always @(posedge clk) begin
		cipher.ready <= no_idle || ($urandom_range(99) >= 25);
	end

	// Every block taken by the receiver is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && cipher.valid && cipher.ready)
			sb.check_result({cipher.cipher_block, cipher.final_block});
	end

	// One plaintext word across the handshake, with random idle cycles ahead of it.
	// Called and returning at a rising edge; valid is assigned once per edge.
	task automatic send_word(input logic [7:0] data, input logic start,
		input logic [15:0] len, input logic [4:0] head, input logic [7:0] fill,
		input logic [15:0] salt);
		plain_word_t w;
		w = {data, start, len, head, fill, salt};
		while (!no_idle && $urandom_range(99) < 25) begin
			plain.valid <= 1'b0;
			@(posedge clk);
		end
		plain.valid          <= 1'b1;
		plain.data_byte      <= data;
		plain.start_req      <= start;
		plain.message_length <= len;
		plain.rand_head      <= head;
		plain.rand_fill      <= fill;
		plain.rand_salt      <= salt;
		@(posedge clk);
		while (!plain.ready) @(posedge clk);
		if (sb.note_input(w)) words_sent++;
	endtask

	// A message of len bytes with random content; only the first stop_after
	// words go out, so a smaller stop_after leaves it open for a later start
	// to abandon. Non-start words carry random junk in the start-only fields.
	task automatic send_message(input logic [15:0] len, input int unsigned stop_after);
		int unsigned words;
		words = (len == 0) ? 1 : ((len < stop_after) ? len : stop_after);
		for (int unsigned i = 0; i < words; i++)
			send_word(8'($urandom), i == 0, (i == 0) ? len : 16'($urandom),
				5'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// Key writes, back to back; the block must be idle.
	task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
		input logic [31:0] k2, input logic [31:0] k3);
		logic [tcme_pkg::CFG_IDX_W-1:0] idx [4];
		logic [31:0]                    val [4];
		idx = '{tcme_pkg::CFG_KEY0, tcme_pkg::CFG_KEY1, tcme_pkg::CFG_KEY2,
			tcme_pkg::CFG_KEY3};
		val = '{k0, k1, k2, k3};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_key(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Stop sending, wait for every expected block, then let the engine settle.
	task automatic drain();
		plain.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly complete messages; the rest abandoned messages with wild lengths,
	// zero-length starts and stray bytes.
	task automatic random_phase(input int unsigned quota);
		int unsigned target;
		int unsigned pick;
		target = words_sent + quota;
		while (words_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				send_message(16'($urandom_range(24, 1)), 32'd65535);
			end else if (pick < 80) begin
				send_message(16'($urandom_range(120, 25)), 32'd65535);
			end else if (pick < 88) begin
				// any length, cut short; high length bits get exercised here
				send_message(16'($urandom), $urandom_range(12, 1));
			end else if (pick < 93) begin
				send_word(8'($urandom), 1'b1, 16'd0, 5'($urandom), 8'($urandom),
					16'($urandom));
			end else begin
				repeat ($urandom_range(3, 1))
					send_word(8'($urandom), 1'b0, 16'($urandom), 5'($urandom),
						8'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		plain.valid          = 1'b0;
		plain.data_byte      = '0;
		plain.start_req      = 1'b0;
		plain.message_length = '0;
		plain.rand_head      = '0;
		plain.rand_fill      = '0;
		plain.rand_salt      = '0;
		cfg_we               = 1'b0;
		cfg_index            = tcme_pkg::CFG_KEY0;
		cfg_data             = '0;
		no_idle              = 0;
		words_sent           = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, keys still at their all-zero reset value.
		// byte with no message open: dropped
		send_word(8'hFF, 1'b0, 16'hFFFF, 5'h1F, 8'hFF, 16'hFFFF);
		// zero-length start: rejected
		send_word(8'hA5, 1'b1, 16'd0, 5'h1F, 8'hFF, 16'hFFFF);
		// one-byte messages with data and random fields at both extremes:
		// a full framing block, then the closing block
		send_word(8'h00, 1'b1, 16'd1, 5'h00, 8'h00, 16'h0000);
		send_word(8'hFF, 1'b1, 16'd1, 5'h1F, 8'hFF, 16'hFFFF);
		send_message(16'd2, 2);
		// longest length, abandoned by the next start
		send_message(16'hFFFF, 3);
		send_message(16'd9, 9);
		// zero-length start in mid message closes it; the next byte is dropped
		send_message(16'd5, 2);
		send_word(8'($urandom), 1'b1, 16'd0, 5'($urandom), 8'($urandom), 16'($urandom));
		send_word(8'h3C, 1'b0, 16'd7, 5'h0A, 8'h55, 16'h1234);
		drain();

		load_keys($urandom, $urandom, $urandom, $urandom);
		random_phase(PHASE_WORDS);
		drain();

		// all-ones keys, with neither side idling through the whole phase
		load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		no_idle <= 1;
		random_phase(PHASE_WORDS);
		no_idle <= 0;
		drain();

		load_keys(32'h0, 32'h0, 32'h0, 32'h0);
		random_phase(PHASE_WORDS);
		drain();

		load_keys($urandom, $urandom, $urandom, $urandom);
		random_phase(PHASE_WORDS);
		drain();

		if (sb.errors == 0)
			$display("tea_chained_message_encrypt test passed");
		else
			$display("tea_chained_message_encrypt test failed");
		$finish;
	end

endmodule

FILE: files.f
design/tcme_pkg.sv
design/tcme_if.sv
design/tcme_front.sv
design/tcme_job_fifo.sv
design/tcme_tea_engine.sv
design/tea_chained_message_encrypt.sv
dv/tb_tea_chained_message_encrypt.sv
